FILE: rtl/core/thick_line_quad_expansion_unit_assert.svh
// Assertion macros for the thick line quad expansion unit.
// Included by the top level; needs nothing else.
`ifndef THICK_LINE_QUAD_EXPANSION_UNIT_ASSERT_SVH
`define THICK_LINE_QUAD_EXPANSION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TLQE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TLQE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define TLQE_ASSERT(label, clk, rst, prop, msg)
`define TLQE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/tlqe_pkg.sv
// Shared types and helpers of the thick line quad expansion unit.
// No dependencies.
package tlqe_pkg;
   localparam int unsigned SQRT_CELLS = 17;
   localparam int unsigned DIV_CELLS  = 12;
   localparam int unsigned FRONT_REGS = 3;
   localparam int unsigned N_STAGES   = FRONT_REGS + SQRT_CELLS + DIV_CELLS + 1;
   localparam int unsigned IN_BITS    = 112;
   localparam int unsigned OUT_BITS   = 160;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      logic [31:0]        color;
      logic [11:0]        th;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [33:0]        dx2;
      logic [33:0]        dy2;
      logic [28:0]        px;
      logic [28:0]        py;
      logic [33:0]        sq;
      logic [19:0]        rem;
      logic [16:0]        root;
      logic [17:0]        den;
      logic [28:0]        rx;
      logic [28:0]        ry;
      logic [11:0]        qx;
      logic [11:0]        qy;
      logic               neg_x;
      logic               neg_y;
      logic               zero;
   } item_type;

   function automatic logic [15:0] sat16(input logic signed [17:0] v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction
endpackage

FILE: rtl/core/tlqe_front.sv
// Front of the pipe: differences, squares and products, then the radicand.
// Uses tlqe_pkg.
module tlqe_front import tlqe_pkg::*; (
   input  logic                clock,
   input  logic [2:0]          en,
   input  logic [IN_BITS-1:0]  req_tdata,
   output item_type            item
);
   item_type s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [16:0] adx, ady;

   always_comb begin
      s0_in       = '0;
      s0_in.sx    = req_tdata[15:0];
      s0_in.sy    = req_tdata[31:16];
      s0_in.ex    = req_tdata[47:32];
      s0_in.ey    = req_tdata[63:48];
      s0_in.th    = req_tdata[75:64];
      s0_in.color = req_tdata[107:76];
      s0_in.dx    = {s0_in.ex[15], s0_in.ex} - {s0_in.sx[15], s0_in.sx};
      s0_in.dy    = {s0_in.ey[15], s0_in.ey} - {s0_in.sy[15], s0_in.sy};
   end

   always_comb begin
      adx         = s0_ff.dx[16] ? 17'(-s0_ff.dx) : s0_ff.dx;
      ady         = s0_ff.dy[16] ? 17'(-s0_ff.dy) : s0_ff.dy;
      s1_in       = s0_ff;
      s1_in.dx2   = 34'(adx) * 34'(adx);
      s1_in.dy2   = 34'(ady) * 34'(ady);
      // x offset is -dy scaled, y offset is dx scaled
      s1_in.px    = 29'(ady) * 29'(s0_ff.th);
      s1_in.py    = 29'(adx) * 29'(s0_ff.th);
      s1_in.neg_x = !s0_ff.dy[16] && (s0_ff.dy != '0);
      s1_in.neg_y = s0_ff.dx[16];
      s1_in.zero  = (s0_ff.dx == '0) && (s0_ff.dy == '0);
   end

   always_comb begin
      s2_in      = s1_ff;
      s2_in.sq   = s1_ff.dx2 + s1_ff.dy2;
      s2_in.rem  = '0;
      s2_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= s0_in;
      end
      if (en[1]) begin
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         s2_ff <= s2_in;
      end
   end

   assign item = s2_ff;
endmodule

FILE: rtl/core/tlqe_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
// Uses tlqe_pkg.
module tlqe_sqrt_cell import tlqe_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  item_type d,
   output item_type q
);
   item_type    q_ff, q_in;
   logic [19:0] r, t;

   always_comb begin
      q_in = d;
      // bring down the next two radicand bits
      r    = {d.rem[17:0], d.sq[33:32]};
      t    = {1'b0, d.root, 2'b01};
      if (r >= t) begin
         q_in.rem  = r - t;
         q_in.root = {d.root[15:0], 1'b1};
      end else begin
         q_in.rem  = r;
         q_in.root = {d.root[15:0], 1'b0};
      end
      q_in.sq = {d.sq[31:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

FILE: rtl/core/tlqe_div_cell.sv
// One cell of the divide chain: one quotient bit for each offset component.
// Uses tlqe_pkg.
module tlqe_div_cell import tlqe_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic     clock,
   input  logic     en,
   input  item_type d,
   output item_type q
);
   item_type    q_ff, q_in;
   logic [29:0] dsh;

   always_comb begin
      q_in = d;
      dsh  = 30'(d.den) << STEP;
      if ({1'b0, d.rx} >= dsh) begin
         q_in.rx       = 29'({1'b0, d.rx} - dsh);
         q_in.qx[STEP] = 1'b1;
      end
      if ({1'b0, d.ry} >= dsh) begin
         q_in.ry       = 29'({1'b0, d.ry} - dsh);
         q_in.qy[STEP] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

FILE: rtl/core/tlqe_corner.sv
// Output stage: applies the offset signs, forms and saturates the corners.
// Uses tlqe_pkg.
module tlqe_corner import tlqe_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  item_type            d,
   output logic [OUT_BITS-1:0] tdata
);
   logic [OUT_BITS-1:0] tdata_ff, tdata_in;
   logic signed [12:0]  ox, oy;

   always_comb begin
      // zero length: drop the offset, the quotient is meaningless
      if (d.zero) begin
         ox = '0;
         oy = '0;
      end else begin
         ox = d.neg_x ? -13'(d.qx) : 13'(d.qx);
         oy = d.neg_y ? -13'(d.qy) : 13'(d.qy);
      end
      tdata_in[15:0]    = sat16(18'(d.sx) - 18'(ox));
      tdata_in[31:16]   = sat16(18'(d.sy) - 18'(oy));
      tdata_in[47:32]   = sat16(18'(d.sx) + 18'(ox));
      tdata_in[63:48]   = sat16(18'(d.sy) + 18'(oy));
      tdata_in[79:64]   = sat16(18'(d.ex) + 18'(ox));
      tdata_in[95:80]   = sat16(18'(d.ey) + 18'(oy));
      tdata_in[111:96]  = sat16(18'(d.ex) - 18'(ox));
      tdata_in[127:112] = sat16(18'(d.ey) - 18'(oy));
      tdata_in[159:128] = d.color;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tdata_ff <= tdata_in;
      end
   end

   assign tdata = tdata_ff;
endmodule

FILE: rtl/core/thick_line_quad_expansion_unit.sv
// Thick line quad expansion: segment in, four quad corners out.
// Uses tlqe_pkg, tlqe_front, tlqe_sqrt_cell, tlqe_div_cell, tlqe_corner.
//
//   channel  dir  beat contents
//   req_     in   segment endpoints, thickness, colour
//   rsp_     out  four corners and colour
//
// One segment per clock sustained while rsp_tready is high; the stages are 3 front registers,
// 17 square root cells, 12 divide cells and the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and new beats enter while a result waits at rsp_.
// Reset clears only the stage valid bits.
`include "thick_line_quad_expansion_unit_assert.svh"
module thick_line_quad_expansion_unit import tlqe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // start_x, start_y, end_x, end_y, thickness, color, 4 bits zero
   input  logic [IN_BITS-1:0]  req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // bl_x, bl_y, tl_x, tl_y, tr_x, tr_y, br_x, br_y, vertex_color
   output logic [OUT_BITS-1:0] rsp_tdata
);
   localparam int unsigned SQ0 = FRONT_REGS;
   localparam int unsigned DV0 = FRONT_REGS + SQRT_CELLS;

   logic [N_STAGES-1:0] valid_ff, valid_in, en;
   item_type            sq_item [SQRT_CELLS+1];
   item_type            dv_item [DIV_CELLS+1];
   item_type            prep;

   assign en[N_STAGES-1] = !valid_ff[N_STAGES-1] || rsp_tready;
   for (genvar i = 0; i < N_STAGES - 1; i++) begin : g_en
      assign en[i] = !valid_ff[i] || en[i+1];
   end

   assign valid_in = {valid_ff[N_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < N_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[N_STAGES-1];

   tlqe_front u_front (
      .clock     (clock),
      .en        (en[2:0]),
      .req_tdata (req_tdata),
      .item      (sq_item[0])
   );

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      tlqe_sqrt_cell u_cell (
         .clock (clock),
         .en    (en[SQ0+i]),
         .d     (sq_item[i]),
         .q     (sq_item[i+1])
      );
   end

   // divisor is twice the length; the length added to each numerator rounds
   always_comb begin
      prep     = sq_item[SQRT_CELLS];
      prep.den = {prep.root, 1'b0};
      prep.rx  = prep.px + 29'(prep.root);
      prep.ry  = prep.py + 29'(prep.root);
      prep.qx  = '0;
      prep.qy  = '0;
   end

   assign dv_item[0] = prep;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      tlqe_div_cell #(
         .STEP (DIV_CELLS - 1 - i)
      ) u_cell (
         .clock (clock),
         .en    (en[DV0+i]),
         .d     (dv_item[i]),
         .q     (dv_item[i+1])
      );
   end

   tlqe_corner u_corner (
      .clock (clock),
      .en    (en[N_STAGES-1]),
      .d     (dv_item[DIV_CELLS]),
      .tdata (rsp_tdata)
   );

   `TLQE_ASSERT_IMP(a_full_stall, clock, reset, (&valid_ff) && !rsp_tready, !req_tready, "full pipe must refuse beats")
   `TLQE_ASSERT_IMP(a_occupancy, clock, reset, !$past(reset), $countones(valid_ff) == $past($countones(valid_ff)) + $past(req_tvalid && req_tready) - $past(rsp_tvalid && rsp_tready), "beat lost or invented")
endmodule
